### rtl/nirtx_pkg.sv
// shared types and constants for the nec infrared frame transmitter
package nirtx_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_CARRIER_HALF = 3'd0,
		CFG_LEADER_MARK  = 3'd1,
		CFG_LEADER_SPACE = 3'd2,
		CFG_BIT_MARK     = 3'd3,
		CFG_ONE_SPACE    = 3'd4,
		CFG_ZERO_SPACE   = 3'd5
	} cfg_idx_t;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CAR_W      = 8;
	localparam int unsigned SEG_W      = 16;
	localparam int unsigned WORD_W     = 32;

	// reset values of the timing registers
	localparam logic [CAR_W-1:0] RST_CARRIER_HALF = 8'd13;
	localparam logic [SEG_W-1:0] RST_LEADER_MARK  = 16'd9000;
	localparam logic [SEG_W-1:0] RST_LEADER_SPACE = 16'd4500;
	localparam logic [SEG_W-1:0] RST_BIT_MARK     = 16'd562;
	localparam logic [SEG_W-1:0] RST_ONE_SPACE    = 16'd1687;
	localparam logic [SEG_W-1:0] RST_ZERO_SPACE   = 16'd562;

	// item function codes
	localparam logic FUNC_TICK  = 1'b0;
	localparam logic FUNC_START = 1'b1;

	// frame phases
	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_LEAD_MARK  = 3'd1,
		PH_LEAD_SPACE = 3'd2,
		PH_BIT_MARK   = 3'd3,
		PH_BIT_SPACE  = 3'd4,
		PH_STOP_MARK  = 3'd5,
		PH_STOP_SPACE = 3'd6
	} phase_t;

	// timing register set
	typedef struct packed {
		logic [CAR_W-1:0] carrier_half;
		logic [SEG_W-1:0] leader_mark;
		logic [SEG_W-1:0] leader_space;
		logic [SEG_W-1:0] bit_mark;
		logic [SEG_W-1:0] one_space;
		logic [SEG_W-1:0] zero_space;
	} cfg_t;

	// one result beat
	typedef struct packed {
		logic level;
		logic busy;
		logic done;
	} res_t;

endpackage

### rtl/nirtx_regs.sv
// timing configuration registers of the nec infrared transmitter
module nirtx_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [nirtx_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [nirtx_pkg::CFG_DATA_W-1:0]   cfg_data,
	output nirtx_pkg::cfg_t                    cfg
);
	import nirtx_pkg::*;

	cfg_t cfg_q;

	// register writes, indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.carrier_half <= RST_CARRIER_HALF;
			cfg_q.leader_mark  <= RST_LEADER_MARK;
			cfg_q.leader_space <= RST_LEADER_SPACE;
			cfg_q.bit_mark     <= RST_BIT_MARK;
			cfg_q.one_space    <= RST_ONE_SPACE;
			cfg_q.zero_space   <= RST_ZERO_SPACE;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CARRIER_HALF: cfg_q.carrier_half <= cfg_data[CAR_W-1:0];
				CFG_LEADER_MARK:  cfg_q.leader_mark  <= cfg_data[SEG_W-1:0];
				CFG_LEADER_SPACE: cfg_q.leader_space <= cfg_data[SEG_W-1:0];
				CFG_BIT_MARK:     cfg_q.bit_mark     <= cfg_data[SEG_W-1:0];
				CFG_ONE_SPACE:    cfg_q.one_space    <= cfg_data[SEG_W-1:0];
				CFG_ZERO_SPACE:   cfg_q.zero_space   <= cfg_data[SEG_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/nirtx_seq.sv
// frame sequencer: phase machine, segment and carrier counters, bit shifter
module nirtx_seq #(
	parameter int unsigned FRAME_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step_en,
	input  logic                               func,
	input  logic [nirtx_pkg::WORD_W-1:0]       frame_word,
	input  nirtx_pkg::cfg_t                    cfg,
	output nirtx_pkg::res_t                    res
);
	import nirtx_pkg::*;

	localparam int unsigned BITS_W = $clog2(FRAME_BITS + 1);

	phase_t              phase_q, phase_d;
	logic [SEG_W-1:0]    seg_cnt_q, seg_cnt_d;
	logic [CAR_W-1:0]    car_cnt_q, car_cnt_d;
	logic                car_lvl_q, car_lvl_d;
	logic [BITS_W-1:0]   bits_left_q, bits_left_d;
	logic [WORD_W-1:0]   shift_q, shift_d;

	logic                in_mark;
	logic                idle;
	logic [SEG_W-1:0]    seg_len;
	logic [SEG_W-1:0]    seg_nxt;
	logic                seg_end;
	logic [CAR_W-1:0]    car_nxt;
	logic                car_flip;
	logic [BITS_W-1:0]   bits_dec;

	// shared decode of the current segment
	assign idle    = (phase_q == PH_IDLE);
	assign in_mark = (phase_q == PH_LEAD_MARK) || (phase_q == PH_BIT_MARK) ||
	                 (phase_q == PH_STOP_MARK);
	assign seg_nxt  = seg_cnt_q + SEG_W'(1);
	assign seg_end  = (seg_nxt >= seg_len) || (seg_nxt == '0);
	assign car_nxt  = car_cnt_q + CAR_W'(1);
	assign car_flip = (car_nxt >= cfg.carrier_half);
	assign bits_dec = bits_left_q - BITS_W'(1);

	// length of the segment in progress
	always_comb begin
		case (phase_q)
			PH_LEAD_MARK:  seg_len = cfg.leader_mark;
			PH_LEAD_SPACE: seg_len = cfg.leader_space;
			PH_BIT_MARK:   seg_len = cfg.bit_mark;
			PH_BIT_SPACE:  seg_len = shift_q[0] ? cfg.one_space : cfg.zero_space;
			PH_STOP_MARK:  seg_len = cfg.bit_mark;
			default:       seg_len = cfg.zero_space;
		endcase
	end

	// next state
	always_comb begin
		phase_t ph_ent;
		logic   ent;
		ph_ent      = PH_IDLE;
		ent         = 1'b0;
		phase_d     = phase_q;
		seg_cnt_d   = seg_cnt_q;
		car_cnt_d   = car_cnt_q;
		car_lvl_d   = car_lvl_q;
		bits_left_d = bits_left_q;
		shift_d     = shift_q;
		if (step_en) begin
			if (func == FUNC_START) begin
				if (idle) begin
					shift_d     = frame_word;
					bits_left_d = BITS_W'(FRAME_BITS);
					ph_ent      = PH_LEAD_MARK;
					ent         = 1'b1;
				end
			end else if (!idle) begin
				if (in_mark) begin
					car_cnt_d = car_flip ? '0 : car_nxt;
					car_lvl_d = car_lvl_q ^ car_flip;
				end
				seg_cnt_d = seg_nxt;
				if (seg_end) begin
					ent = 1'b1;
					case (phase_q)
						PH_LEAD_MARK:  ph_ent = PH_LEAD_SPACE;
						PH_LEAD_SPACE: ph_ent = (bits_left_q != '0) ? PH_BIT_MARK
						                                            : PH_STOP_MARK;
						PH_BIT_MARK:   ph_ent = PH_BIT_SPACE;
						PH_BIT_SPACE: begin
							shift_d     = shift_q >> 1;
							bits_left_d = bits_dec;
							ph_ent      = (bits_dec != '0) ? PH_BIT_MARK : PH_STOP_MARK;
						end
						PH_STOP_MARK:  ph_ent = PH_STOP_SPACE;
						default:       ph_ent = PH_IDLE;
					endcase
				end
			end
		end
		// entering a segment restarts the counters, marks open high
		if (ent) begin
			phase_d   = ph_ent;
			seg_cnt_d = '0;
			car_cnt_d = '0;
			car_lvl_d = (ph_ent == PH_LEAD_MARK) || (ph_ent == PH_BIT_MARK) ||
			            (ph_ent == PH_STOP_MARK);
		end
	end

	// result of the item
	always_comb begin
		res = '0;
		if (func == FUNC_START) begin
			res.busy  = 1'b1;
			res.level = idle ? 1'b1 : (in_mark & car_lvl_q);
		end else if (!idle) begin
			res.busy  = 1'b1;
			res.level = in_mark & car_lvl_q;
			res.done  = seg_end && (phase_q == PH_STOP_SPACE);
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			seg_cnt_q   <= '0;
			car_cnt_q   <= '0;
			car_lvl_q   <= 1'b0;
			bits_left_q <= '0;
			shift_q     <= '0;
		end else begin
			phase_q     <= phase_d;
			seg_cnt_q   <= seg_cnt_d;
			car_cnt_q   <= car_cnt_d;
			car_lvl_q   <= car_lvl_d;
			bits_left_q <= bits_left_d;
			shift_q     <= shift_d;
		end
	end

endmodule

### rtl/nirtx_out.sv
// result register with valid and stall toward the receiver
module nirtx_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  nirtx_pkg::res_t   res,
	output logic              accept,
	output logic              out_valid,
	input  logic              out_stall,
	output nirtx_pkg::res_t   out_res
);
	import nirtx_pkg::*;

	logic out_valid_q;
	res_t res_q;

	// take a new beat whenever the held one leaves or none is held
	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

endmodule

### rtl/nec_ir_frame_transmitter_core.sv
// top level of the nec infrared frame transmitter
// Usage: each input beat is either a tick (func = 0), standing for one
// microsecond of time, or a start (func = 1) that loads frame_word when the
// transmitter is idle; a start while a frame is going out is ignored.
// Every input beat gives exactly one result beat: ir_level (the pin level
// during that tick, carrier gated by marks), busy_res and frame_done, which
// is set on the tick that closes the stop space.
// Frame: leader mark, leader space, FRAME_BITS bits lsb first (bit mark and
// a one or zero space), then stop mark and stop space.
// A result beat shows in the cycle after its input beat is taken; a beat
// is taken every cycle unless the receiver stalls: the sequencer updates
// its counters in one pass and the result register holds the beat.
// When the receiver stalls, the held result stays and in_stall rises, so
// the input side waits; the beat is taken in the cycle the result leaves.
// Reset (arst_n low) returns to idle with empty output and loads the
// default timing: 13 carrier half ticks, 9000/4500 leader, 562 bit mark,
// 1687 one space, 562 zero space. The user must write timing registers
// through cfg_wr_en, cfg_index, cfg_data only while idle; not enforced.
module nec_ir_frame_transmitter_core #(
	parameter int unsigned FRAME_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [nirtx_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [nirtx_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               func,
	input  logic [nirtx_pkg::WORD_W-1:0]       frame_word,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               ir_level,
	output logic                               busy_res,
	output logic                               frame_done
);
	import nirtx_pkg::*;

	cfg_t cfg;
	res_t res;
	res_t out_res;
	logic accept;

	// timing registers
	nirtx_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// frame sequencer
	nirtx_seq #(
		.FRAME_BITS (FRAME_BITS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (accept),
		.func       (func),
		.frame_word (frame_word),
		.cfg        (cfg),
		.res        (res)
	);

	// result register
	nirtx_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.res       (res),
		.accept    (accept),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign ir_level   = out_res.level;
	assign busy_res   = out_res.busy;
	assign frame_done = out_res.done;

endmodule

### rtl/nirtx_chk.sv
// port checker for the nec infrared frame transmitter, bound to the top level
module nirtx_chk (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic ir_level,
	input logic busy_res,
	input logic frame_done
);

	// a stalled result beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ir_level) &&
		$stable(busy_res) && $stable(frame_done))
		else $error("stalled result beat changed");

	// input is only held back by a waiting result
	a_stall_cause: assert property (@(posedge clk)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	// carrier only shows while a frame is in flight
	a_level_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ir_level |-> busy_res)
		else $error("pin high while idle");

	// frame end is reported on a busy tick
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> busy_res && !ir_level)
		else $error("frame done outside the stop space");

endmodule

bind nec_ir_frame_transmitter_core nirtx_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.ir_level   (ir_level),
	.busy_res   (busy_res),
	.frame_done (frame_done)
);
